FILE: hw/rtl/dad_pkg.sv
// Shared types, constants and calendar functions of the date adder.
package dad_pkg;

    localparam int YEAR_BITS  = 16;
    localparam int YEAR_W     = YEAR_BITS + 1;
    localparam int DAY_W      = 18;
    localparam int OFF_W      = 17;
    localparam int MONTH_W    = 4;
    localparam int MDAY_W     = 5;
    localparam int YMOD_W     = 9;
    localparam int MOD_BASE   = 400;
    localparam int FIRST_YEAR = 1582;

    // Year / 400 as (year >> 4) / 25, the divide by 25 by reciprocal multiply.
    localparam int     MOD_SHIFT   = 4;
    localparam int     RECIP_SHIFT = YEAR_BITS + 1;
    localparam int     RECIP_W     = YEAR_BITS - 3;
    localparam longint RECIP_25    = ((longint'(1) << RECIP_SHIFT) + 24) / 25;
    localparam int     PROD_W      = YEAR_BITS - MOD_SHIFT + RECIP_W;
    localparam int     QUOT_W      = YEAR_BITS - 8;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [YMOD_W-1:0] YMOD_100  = 9'd100;
    localparam logic [YMOD_W-1:0] YMOD_200  = 9'd200;
    localparam logic [YMOD_W-1:0] YMOD_300  = 9'd300;
    localparam logic [YMOD_W-1:0] YMOD_LAST = 9'd399;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INPUT = 2'd1,
        ST_TOO_EARLY = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                move;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [YMOD_W-1:0]   ymod;
    } t_step;

    // Leap rule applied to the year modulo 400.
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        return (ymod[1:0] == 2'b00) && (ymod != YMOD_100) &&
               (ymod != YMOD_200) && (ymod != YMOD_300);
    endfunction

    function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [MDAY_W-1:0] len;
        unique case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB:                            len = leap ? 5'd29 : 5'd28;
            default:                            len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: hw/rtl/dad_if.sv
// Valid/ready channel interfaces for the date adder's input and result.
interface dad_in_if;
    logic                              valid;
    logic                              ready;
    logic [dad_pkg::YEAR_BITS-1:0]     start_year;
    logic [dad_pkg::MONTH_W-1:0]       start_month;
    logic [dad_pkg::MDAY_W-1:0]        start_day;
    logic signed [dad_pkg::OFF_W-1:0]  day_offset;

    modport source (output valid, start_year, start_month, start_day, day_offset,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, day_offset,
                    output ready);
endinterface

interface dad_out_if;
    logic                          valid;
    logic                          ready;
    logic [dad_pkg::YEAR_BITS-1:0] result_year;
    logic [dad_pkg::MONTH_W-1:0]   result_month;
    logic [dad_pkg::MDAY_W-1:0]    result_day;
    logic [1:0]                    status;

    modport source (output valid, result_year, result_month, result_day, status,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, status,
                    output ready);
endinterface

FILE: hw/rtl/dad_mod400.sv
// Year modulo 400: shift, reciprocal multiply, subtract; quotient and remainder registered.
module dad_mod400 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dad_pkg::YEAR_BITS-1:0] i_year,
    output logic                          o_done,
    output logic [dad_pkg::YMOD_W-1:0]    o_rem
);

    logic [dad_pkg::YEAR_BITS-1:0] r_year;
    logic [dad_pkg::QUOT_W-1:0]    r_quot;
    logic [dad_pkg::YMOD_W-1:0]    r_rem;
    logic                          r_quot_en;
    logic                          r_rem_en;
    logic                          r_done;
    logic [dad_pkg::PROD_W-1:0]    w_prod;
    logic [dad_pkg::YEAR_BITS-1:0] w_diff;

    // quotient by 16 with a shift, then by 25 with a reciprocal multiply
    assign w_prod = dad_pkg::PROD_W'(r_year[dad_pkg::YEAR_BITS-1:dad_pkg::MOD_SHIFT]) *
                    dad_pkg::PROD_W'(dad_pkg::RECIP_25);
    assign w_diff = r_year - (dad_pkg::YEAR_BITS'(r_quot) *
                              dad_pkg::YEAR_BITS'(dad_pkg::MOD_BASE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot_en <= 1'b0;
            r_rem_en  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_quot_en <= i_start;
            r_rem_en  <= r_quot_en;
            r_done    <= r_rem_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_year <= i_year;
        end
        if (r_quot_en) begin
            r_quot <= w_prod[dad_pkg::PROD_W-1:dad_pkg::RECIP_SHIFT];
        end
        if (r_rem_en) begin
            r_rem <= w_diff[dad_pkg::YMOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/dad_step.sv
// One month step of the calendar walk, forward or backward.
module dad_step (
    input  logic [dad_pkg::YEAR_W-1:0]  i_year,
    input  logic [dad_pkg::MONTH_W-1:0] i_month,
    input  logic [dad_pkg::DAY_W-1:0]   i_day,
    input  logic [dad_pkg::YMOD_W-1:0]  i_ymod,
    output dad_pkg::t_step              o_step
);

    logic [dad_pkg::MDAY_W-1:0]  w_len_cur;
    logic [dad_pkg::MDAY_W-1:0]  w_len_prev;
    logic                        w_fwd;
    logic                        w_bwd;
    logic [dad_pkg::MONTH_W-1:0] w_prev_month;
    logic [dad_pkg::YEAR_W-1:0]  w_prev_year;
    logic [dad_pkg::YMOD_W-1:0]  w_prev_ymod;

    assign w_len_cur = dad_pkg::month_len(i_month, dad_pkg::is_leap(i_ymod));
    assign w_fwd = $signed(i_day) > $signed({{(dad_pkg::DAY_W-dad_pkg::MDAY_W){1'b0}},
                                             w_len_cur});
    assign w_bwd = i_day[dad_pkg::DAY_W-1] || (i_day == '0);

    always_comb begin
        if (i_month == dad_pkg::MON_JAN) begin
            w_prev_month = dad_pkg::MON_DEC;
            w_prev_year  = i_year - 1'b1;
            w_prev_ymod  = (i_ymod == '0) ? dad_pkg::YMOD_LAST : i_ymod - 1'b1;
        end else begin
            w_prev_month = i_month - 1'b1;
            w_prev_year  = i_year;
            w_prev_ymod  = i_ymod;
        end
    end

    assign w_len_prev = dad_pkg::month_len(w_prev_month, dad_pkg::is_leap(w_prev_ymod));

    always_comb begin
        o_step.move  = w_fwd || w_bwd;
        o_step.year  = i_year;
        o_step.month = i_month;
        o_step.day   = i_day;
        o_step.ymod  = i_ymod;
        if (w_fwd) begin
            o_step.day = i_day - {{(dad_pkg::DAY_W-dad_pkg::MDAY_W){1'b0}}, w_len_cur};
            if (i_month == dad_pkg::MON_DEC) begin
                o_step.month = dad_pkg::MON_JAN;
                o_step.year  = i_year + 1'b1;
                o_step.ymod  = (i_ymod == dad_pkg::YMOD_LAST) ? '0 : i_ymod + 1'b1;
            end else begin
                o_step.month = i_month + 1'b1;
            end
        end else if (w_bwd) begin
            o_step.month = w_prev_month;
            o_step.year  = w_prev_year;
            o_step.ymod  = w_prev_ymod;
            o_step.day   = i_day + {{(dad_pkg::DAY_W-dad_pkg::MDAY_W){1'b0}}, w_len_prev};
        end
    end

endmodule

FILE: hw/rtl/date_add_days.sv
// Top level of the Gregorian date adder: sequencer, walk registers and result register.
//
// The block takes a Gregorian date and a signed day offset and returns the
// date that lies that many days away, with a status code: ok, invalid start
// date (year before 1582, month outside 1..12, day outside its month), result
// before 1582, or result year beyond the year field. On any error the date
// fields read zero. One item is handled at a time: after a transfer in, the
// input is not ready until the result has been transferred out, and it is
// ready again the cycle after that transfer. The remainder unit first reduces
// the year modulo 400 (a shift, a reciprocal multiply and a subtract), then
// the start date is checked, then the single month-step unit crosses one
// month per walk step, and a last walk step finds the day inside its month
// and sets the result; the largest offset of 65535 days crosses roughly 2150
// months. An invalid start date skips the walk.
module date_add_days (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dad_in_if.sink   i_in,
    dad_out_if.source o_out
);

    dad_pkg::t_state r_state, n_state;

    // walk registers
    logic [dad_pkg::YEAR_W-1:0]   r_year,  n_year;
    logic [dad_pkg::MONTH_W-1:0]  r_month, n_month;
    logic [dad_pkg::DAY_W-1:0]    r_day,   n_day;
    logic [dad_pkg::YMOD_W-1:0]   r_ymod,  n_ymod;
    logic [dad_pkg::OFF_W-1:0]    r_off,   n_off;

    // result register
    logic [dad_pkg::YEAR_BITS-1:0] r_res_year,  n_res_year;
    logic [dad_pkg::MONTH_W-1:0]   r_res_month, n_res_month;
    logic [dad_pkg::MDAY_W-1:0]    r_res_day,   n_res_day;
    dad_pkg::t_status              r_res_status, n_res_status;

    logic                        w_accept;
    logic                        w_mod_done;
    logic [dad_pkg::YMOD_W-1:0]  w_mod_rem;
    dad_pkg::t_step              w_step;
    logic [dad_pkg::MDAY_W-1:0]  w_start_len;
    logic                        w_bad;

    assign i_in.ready = (r_state == dad_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // Year modulo 400 drives the leap rule for the whole walk.
    dad_mod400 u_mod400 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_year  (i_in.start_year),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // Single month-step unit, reused every cycle of the walk.
    dad_step u_step (
        .i_year  (r_year),
        .i_month (r_month),
        .i_day   (r_day),
        .i_ymod  (r_ymod),
        .o_step  (w_step)
    );

    // Start date validity: r_day still holds the start day during the check.
    assign w_start_len = dad_pkg::month_len(r_month, dad_pkg::is_leap(r_ymod));
    assign w_bad = (r_year < dad_pkg::YEAR_W'(dad_pkg::FIRST_YEAR)) ||
                   (r_month == '0) || (r_month > dad_pkg::MON_DEC) ||
                   (r_day == '0) ||
                   (r_day > {{(dad_pkg::DAY_W-dad_pkg::MDAY_W){1'b0}}, w_start_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dad_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year       <= n_year;
        r_month      <= n_month;
        r_day        <= n_day;
        r_ymod       <= n_ymod;
        r_off        <= n_off;
        r_res_year   <= n_res_year;
        r_res_month  <= n_res_month;
        r_res_day    <= n_res_day;
        r_res_status <= n_res_status;
    end

    always_comb begin
        n_state      = r_state;
        n_year       = r_year;
        n_month      = r_month;
        n_day        = r_day;
        n_ymod       = r_ymod;
        n_off        = r_off;
        n_res_year   = r_res_year;
        n_res_month  = r_res_month;
        n_res_day    = r_res_day;
        n_res_status = r_res_status;

        unique case (r_state)
            dad_pkg::S_IDLE: begin
                // capture the start date on a transfer in
                if (w_accept) begin
                    n_year  = {1'b0, i_in.start_year};
                    n_month = i_in.start_month;
                    n_day   = {{(dad_pkg::DAY_W-dad_pkg::MDAY_W){1'b0}}, i_in.start_day};
                    n_off   = i_in.day_offset;
                    n_state = dad_pkg::S_MOD;
                end
            end
            dad_pkg::S_MOD: begin
                if (w_mod_done) begin
                    n_ymod  = w_mod_rem;
                    n_state = dad_pkg::S_CHECK;
                end
            end
            dad_pkg::S_CHECK: begin
                if (w_bad) begin
                    n_res_year   = '0;
                    n_res_month  = '0;
                    n_res_day    = '0;
                    n_res_status = dad_pkg::ST_BAD_INPUT;
                    n_state      = dad_pkg::S_DONE;
                end else begin
                    // fold the offset into the day and start walking
                    n_day   = r_day + {{(dad_pkg::DAY_W-dad_pkg::OFF_W){r_off[dad_pkg::OFF_W-1]}},
                                       r_off};
                    n_state = dad_pkg::S_WALK;
                end
            end
            dad_pkg::S_WALK: begin
                if (w_step.move) begin
                    n_year  = w_step.year;
                    n_month = w_step.month;
                    n_day   = w_step.day;
                    n_ymod  = w_step.ymod;
                end else begin
                    // day lies inside the month: classify the final year
                    n_res_year   = '0;
                    n_res_month  = '0;
                    n_res_day    = '0;
                    n_state      = dad_pkg::S_DONE;
                    if (r_year < dad_pkg::YEAR_W'(dad_pkg::FIRST_YEAR)) begin
                        n_res_status = dad_pkg::ST_TOO_EARLY;
                    end else if (r_year[dad_pkg::YEAR_W-1]) begin
                        n_res_status = dad_pkg::ST_OVERFLOW;
                    end else begin
                        n_res_status = dad_pkg::ST_OK;
                        n_res_year   = r_year[dad_pkg::YEAR_BITS-1:0];
                        n_res_month  = r_month;
                        n_res_day    = r_day[dad_pkg::MDAY_W-1:0];
                    end
                end
            end
            dad_pkg::S_DONE: begin
                // hold the result until the transfer out
                if (o_out.ready) begin
                    n_state = dad_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dad_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out.valid        = (r_state == dad_pkg::S_DONE);
    assign o_out.result_year  = r_res_year;
    assign o_out.result_month = r_res_month;
    assign o_out.result_day   = r_res_day;
    assign o_out.status       = r_res_status;

    // Never take an item while a result is pending.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while result pending");

    // Error results carry an all-zero date.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != dad_pkg::ST_OK)) |->
        ((o_out.result_year == '0) && (o_out.result_month == '0) &&
         (o_out.result_day == '0)))
        else $error("error result with non-zero date");

    // A good result is a real calendar position.
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == dad_pkg::ST_OK)) |->
        ((o_out.result_month >= dad_pkg::MON_JAN) &&
         (o_out.result_month <= dad_pkg::MON_DEC) && (o_out.result_day != '0)))
        else $error("ok result outside calendar range");

    // The year residue stays below 400 throughout the walk.
    a_ymod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dad_pkg::S_WALK) |-> (r_ymod <= dad_pkg::YMOD_LAST))
        else $error("year residue out of range");

    // The walk only ends once the day lies inside its month.
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dad_pkg::S_WALK) && (n_state == dad_pkg::S_DONE)) |->
        (!r_day[dad_pkg::DAY_W-1] && (r_day != '0)))
        else $error("walk ended with day outside month");

endmodule
